// File: hw/rtl/srpm_pkg.sv
// Shared types and constants for the stereo RMS and peak-hold level meter.
package srpm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEFF_BITS     = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC      = 12;
    localparam int HOLD_LEN_BITS  = 18;
    localparam int MS_BITS        = 2 * SAMPLE_BITS - 1;
    localparam int MS_PROD_BITS   = MS_BITS + COEFF_BITS;
    localparam int GAIN_PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam int MUL_A_BITS     = MS_BITS;
    localparam int MUL_B_BITS     = SAMPLE_BITS;
    localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
    localparam int DECAY_SHIFT    = 16;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [15:0] DECAY_MUL = 16'd65208;
    localparam logic [SAMPLE_BITS-1:0] MAG_MAX_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] MAG_MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    localparam logic [COEFF_BITS-1:0]    COEFF_RESET    = 16'd65326;
    localparam logic [HOLD_LEN_BITS-1:0] HOLD_LEN_RESET = 18'd48000;
    localparam logic [GAIN_BITS-1:0]     GAIN_RESET     = 16'd4096;

    typedef enum logic [2:0] {
        REG_SMOOTHING_COEFF = 3'd0,
        REG_HOLD_LENGTH     = 3'd1,
        REG_INPUT_GAIN      = 3'd2,
        REG_FREEZE          = 3'd3,
        REG_BYPASS          = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SAT,
        ST_SQ,
        ST_MSC,
        ST_MSD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } t_in_word;

    typedef struct packed {
        logic                   meter_channel;
        logic [MS_BITS-1:0]     mean_square;
        logic [SAMPLE_BITS-1:0] block_peak;
        logic [SAMPLE_BITS-1:0] held_peak;
    } t_out_word;

endpackage

// File: hw/rtl/stereo_rms_peak_hold_meter_core.sv
// Stereo RMS and peak-hold level meter with one shared multiplier.
//
// Each input word carries one signed sample for a channel and a block-end
// flag. The sample is scaled by the input gain, then feeds a one-pole mean
// square, a peak-hold level and a block peak kept per channel. A word with
// block_end set produces one output word holding the channel's readings,
// unless freeze is set, and clears that channel's block peak.
// An input word is taken when i_in_valid is high and o_in_stall is low.
// o_in_stall stays high from each accepted word until the sequence is back in idle,
// so a new word is taken only once the last one is through. The single multiplier
// forms the gain, decay, square and two smoothing products in turn.
// A reading is loaded into o_out_word at the final step, after the gain, saturate, square and two smoothing steps. It
// sits in an output register until taken; while i_out_stall holds it, the
// block waits at its final step and does not accept new words.
// With bypass set, or for a channel beyond the configured count, a word is
// accepted and dropped at once. Registers are written over the APB port; the user
// must write them only while the block is idle, which the block itself does not enforce.
// Reset returns all configuration registers to their defaults and clears the channel state.
module stereo_rms_peak_hold_meter_core
    import srpm_pkg::*;
#(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_word                 i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_word                o_out_word,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [COEFF_BITS-1:0]    r_coeff;
    logic [HOLD_LEN_BITS-1:0] r_hold_len;
    logic [GAIN_BITS-1:0]     r_gain;
    logic                     r_freeze;
    logic                     r_bypass;

    logic [MS_BITS-1:0]       r_ms    [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0]   r_hold  [NUM_CHANNELS];
    logic [HOLD_LEN_BITS-1:0] r_cnt   [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0]   r_bpeak [NUM_CHANNELS];

    t_state                   r_state;
    t_state                   n_state;
    logic [CH_W-1:0]          r_ch;
    logic                     r_last;
    logic                     r_neg;
    logic [SAMPLE_BITS-1:0]   r_mag;
    logic [SAMPLE_BITS-1:0]   r_a;
    logic [MS_BITS-1:0]       r_sq;
    logic [MS_PROD_BITS-1:0]  r_acc;
    logic [PROD_BITS-1:0]     r_prod;
    logic                     r_out_valid;
    t_out_word                r_out;

    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;
    logic                     in_accept;
    logic                     in_keep;
    logic                     fin_go;
    logic [MUL_A_BITS-1:0]    mul_a;
    logic [MUL_B_BITS-1:0]    mul_b;
    logic [PROD_BITS-1:0]     n_prod;
    logic [SAMPLE_BITS-1:0]   in_mag;
    logic [GAIN_PROD_BITS:0]  rnd;
    logic [GAIN_PROD_BITS-GAIN_FRAC:0] scaled;
    logic [SAMPLE_BITS-1:0]   sat_lim;
    logic [SAMPLE_BITS-1:0]   n_a;
    logic [SAMPLE_BITS-1:0]   decayed;
    logic [COEFF_BITS:0]      coeff_cmp;
    logic [MS_PROD_BITS:0]    ms_sum;
    logic [HOLD_LEN_BITS-1:0] hold_load;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_SMOOTHING_COEFF: prdata = CFG_DATA_BITS'(r_coeff);
            REG_HOLD_LENGTH:     prdata = CFG_DATA_BITS'(r_hold_len);
            REG_INPUT_GAIN:      prdata = CFG_DATA_BITS'(r_gain);
            REG_FREEZE:          prdata = CFG_DATA_BITS'(r_freeze);
            REG_BYPASS:          prdata = CFG_DATA_BITS'(r_bypass);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff    <= COEFF_RESET;
            r_hold_len <= HOLD_LEN_RESET;
            r_gain     <= GAIN_RESET;
            r_freeze   <= 1'b0;
            r_bypass   <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SMOOTHING_COEFF: r_coeff    <= pwdata[COEFF_BITS-1:0];
                REG_HOLD_LENGTH:     r_hold_len <= pwdata[HOLD_LEN_BITS-1:0];
                REG_INPUT_GAIN:      r_gain     <= pwdata[GAIN_BITS-1:0];
                REG_FREEZE:          r_freeze   <= pwdata[0];
                REG_BYPASS:          r_bypass   <= pwdata[0];
                default:             r_freeze   <= r_freeze;
            endcase
        end
    end

    // Input side.
    assign in_accept = i_in_valid && !o_in_stall;
    assign in_keep   = !r_bypass && (int'(i_in_word.channel) < NUM_CHANNELS);
    assign in_mag    = i_in_word.sample[SAMPLE_BITS-1]
                     ? (~i_in_word.sample + SAMPLE_BITS'(1)) : i_in_word.sample;
    assign fin_go    = !r_out_valid || !i_out_stall;

    // Saturating round of the gain product, the decay shift and the smoothing sum.
    assign rnd       = {1'b0, r_prod[GAIN_PROD_BITS-1:0]}
                     + (GAIN_PROD_BITS+1)'(1 << (GAIN_FRAC - 1));
    assign scaled    = rnd[GAIN_PROD_BITS:GAIN_FRAC];
    assign sat_lim   = r_neg ? MAG_MAX_NEG : MAG_MAX_POS;
    assign n_a       = (scaled > (GAIN_PROD_BITS-GAIN_FRAC+1)'(sat_lim))
                     ? sat_lim : scaled[SAMPLE_BITS-1:0];
    assign decayed   = r_prod[SAMPLE_BITS+DECAY_SHIFT-1:DECAY_SHIFT];
    assign coeff_cmp = {1'b1, {COEFF_BITS{1'b0}}} - {1'b0, r_coeff};
    assign ms_sum    = {1'b0, r_acc} + {1'b0, r_prod[MS_PROD_BITS-1:0]};
    assign hold_load = (r_hold_len == '0) ? HOLD_LEN_BITS'(1) : r_hold_len;
    assign n_prod    = mul_a * mul_b;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept && in_keep) n_state = ST_GAIN;
            ST_GAIN: n_state = ST_SAT;
            ST_SAT:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_MSC;
            ST_MSC:  n_state = ST_MSD;
            ST_MSD:  n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ST_GAIN: begin
                mul_a = MUL_A_BITS'(r_mag);
                mul_b = MUL_B_BITS'(r_gain);
            end
            ST_SAT: begin
                mul_a = MUL_A_BITS'(r_hold[r_ch]);
                mul_b = MUL_B_BITS'(DECAY_MUL);
            end
            ST_SQ: begin
                mul_a = MUL_A_BITS'(r_a);
                mul_b = r_a;
            end
            ST_MSC: begin
                mul_a = r_ms[r_ch];
                mul_b = MUL_B_BITS'(r_coeff);
            end
            ST_MSD: begin
                mul_a = r_sq;
                mul_b = MUL_B_BITS'(coeff_cmp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and per-channel state.
    // The last product is held through the final step so a stalled reading keeps its sum.
    always_ff @(posedge i_clk) begin
        if (r_state != ST_FIN) begin
            r_prod <= n_prod;
        end
        case (r_state)
            ST_IDLE: begin
                r_ch   <= CH_W'(i_in_word.channel);
                r_last <= i_in_word.block_end;
                r_neg  <= i_in_word.sample[SAMPLE_BITS-1];
                r_mag  <= in_mag;
            end
            ST_SAT: r_a <= n_a;
            ST_MSC: r_sq <= r_prod[MS_BITS-1:0];
            ST_MSD: r_acc <= r_prod[MS_PROD_BITS-1:0];
            default: r_a <= r_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_ms[i]    <= '0;
                r_hold[i]  <= '0;
                r_cnt[i]   <= '0;
                r_bpeak[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_SQ: begin
                    if (r_a >= r_hold[r_ch]) begin
                        r_hold[r_ch] <= r_a;
                        r_cnt[r_ch]  <= hold_load;
                    end else if (r_cnt[r_ch] != '0) begin
                        r_cnt[r_ch] <= r_cnt[r_ch] - HOLD_LEN_BITS'(1);
                    end else begin
                        r_hold[r_ch] <= decayed;
                    end
                    if (r_a > r_bpeak[r_ch]) begin
                        r_bpeak[r_ch] <= r_a;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        r_ms[r_ch] <= ms_sum[MS_PROD_BITS-1:COEFF_BITS];
                        if (r_last) begin
                            r_bpeak[r_ch] <= '0;
                        end
                    end
                end
                default: r_ms[r_ch] <= r_ms[r_ch];
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && fin_go && r_last && !r_freeze) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && fin_go && r_last && !r_freeze) begin
            r_out.meter_channel <= r_ch[0];
            r_out.mean_square   <= ms_sum[MS_PROD_BITS-1:COEFF_BITS];
            r_out.block_peak    <= r_bpeak[r_ch];
            r_out.held_peak     <= r_hold[r_ch];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Checks on the sequencer and the output register.
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !fin_go) |=> (r_state == ST_FIN))
        else $error("final step left while output register was blocked");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("output word loaded outside the final step");

    a_keep_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_keep) |=> (r_state == ST_GAIN))
        else $error("accepted word did not start the sequence");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !in_keep) |=> (r_state == ST_IDLE && !$rose(r_out_valid)))
        else $error("dropped word started work");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_hold[r_ch] <= MAG_MAX_NEG
                                 && r_bpeak[r_ch] <= MAG_MAX_NEG))
        else $error("level above full scale");

endmodule
